// ===== sv/dcp_pkg.sv =====
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared sizes, types and status codes of the critical path finder.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 64;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned VtxBits     = 6;
  localparam int unsigned EdgeIdxBits = $clog2(MaxEdges);
  localparam int unsigned CntBits     = $clog2(MaxEdges + 1);
  localparam int unsigned VcntBits    = 7;
  localparam int unsigned TimeBits    = 23;
  localparam int unsigned LenBits     = 22;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned EdgeBits    = 2 * VtxBits + WeightBits;

  localparam logic [StatusBits-1:0] StatusOk    = 2'd0;
  localparam logic [StatusBits-1:0] StatusCycle = 2'd1;
  localparam logic [StatusBits-1:0] StatusRange = 2'd2;

  typedef struct packed {
    logic [VtxBits-1:0]    from_vertex;
    logic [VtxBits-1:0]    to_vertex;
    logic [WeightBits-1:0] weight;
    logic                  last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [VtxBits-1:0]    crit_from;
    logic [VtxBits-1:0]    crit_to;
    logic [WeightBits-1:0] crit_weight;
    logic [LenBits-1:0]    project_length;
    logic                  last;
  } crit_item_t;

endpackage

// ===== sv/dcp_if.sv =====
// ----------------------------------------------------------------------------
// dcp_in_if / dcp_out_if
// Valid/ready channels for edge items and critical edge items.
// ----------------------------------------------------------------------------
interface dcp_in_if;
  import dcp_pkg::*;
  logic       valid;
  logic       ready;
  edge_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcp_out_if;
  import dcp_pkg::*;
  logic       valid;
  logic       ready;
  crit_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/dag_critical_path.sv =====
// ----------------------------------------------------------------------------
// dag_critical_path
// Critical path finder for an activity-on-edge network held in RAM.
// ----------------------------------------------------------------------------
// channel   dir  fields
// edge_in   in   from_vertex to_vertex weight last_edge
// crit_out  out  status crit_from crit_to crit_weight project_length last
// cfg       in   cfg_we_i cfg_wdata_i (vertex_count)
//
// Loading takes one edge item per cycle. The final item starts a run whose
// length is set by the edge RAM read port, which the edge passes scan one
// entry at a time.
// Reset empties the edge list; degree and earliest time arrays are cleared
// at each run start.
// Output stalls freeze the emission scan; no item is taken during a run.
// ----------------------------------------------------------------------------
module dag_critical_path import dcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [VcntBits-1:0] cfg_wdata_i,
  dcp_in_if.sink              edge_in,
  dcp_out_if.source           crit_out
);

  localparam int unsigned VIdx = $clog2(MaxVertices);

  localparam logic [3:0] SLoad  = 4'd0;
  localparam logic [3:0] SRange = 4'd1;
  localparam logic [3:0] SClr   = 4'd2;
  localparam logic [3:0] SDeg   = 4'd3;
  localparam logic [3:0] SSeed  = 4'd4;
  localparam logic [3:0] SPop   = 4'd5;
  localparam logic [3:0] SFwd   = 4'd6;
  localparam logic [3:0] SMax   = 4'd7;
  localparam logic [3:0] SBwd   = 4'd8;
  localparam logic [3:0] SEmit  = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SErr   = 4'd11;

  logic [3:0]          state_q, state_d;
  logic [VcntBits-1:0] vcnt_q;
  logic [CntBits-1:0]  ecnt_q, ecnt_d;
  logic [VcntBits-1:0] nv_q, nv_d;
  logic [CntBits-1:0]  e_q, e_d;       // scan index (issue)
  logic [VcntBits-1:0] v_q, v_d;       // vertex index
  logic [VcntBits-1:0] sp_q, sp_d;
  logic [VcntBits-1:0] done_q, done_d;
  logic [VIdx-1:0]     p_q, p_d;
  logic [TimeBits-1:0] ep_q, ep_d, maxe_q, maxe_d, lp_q, lp_d;
  logic                rv_q, rv_d;     // read data valid
  logic                bad_q, bad_d;   // range flag, edge data pending in backward pass
  logic [1:0]          sub_q, sub_d;   // sub phase within a step
  logic                emitted_q, emitted_d;
  crit_item_t          out_q, out_d;
  crit_item_t          hold_q, hold_d; // newest critical edge, not yet shown
  logic                ov_q, ov_d;

  // edge RAM
  logic                     e_we;
  logic [EdgeIdxBits-1:0]   e_waddr, e_raddr;
  logic [EdgeBits-1:0]      e_wdata, e_rdata;
  logic [VtxBits-1:0]       r_src, r_dst;
  logic [WeightBits-1:0]    r_w;

  // time RAMs: earliest, latest; stack, topo order and in-degree RAMs
  logic                 et_we, lt_we, st_we, to_we, dg_we;
  logic [VIdx-1:0]      et_wa, et_ra, lt_wa, lt_ra, st_wa, st_ra, to_wa, to_ra;
  logic [VIdx-1:0]      dg_wa, dg_ra;
  logic [TimeBits-1:0]  et_wd, et_rd, lt_wd, lt_rd;
  logic [VIdx-1:0]      st_wd, st_rd, to_wd, to_rd;
  logic [VcntBits-1:0]  dg_wd, dg_rd;

  dcp_ram #(.Width(EdgeBits), .Depth(MaxEdges)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata));
  dcp_ram #(.Width(TimeBits), .Depth(MaxVertices)) u_et (
    .clk_i, .we_i(et_we), .waddr_i(et_wa), .wdata_i(et_wd),
    .raddr_i(et_ra), .rdata_o(et_rd));
  dcp_ram #(.Width(TimeBits), .Depth(MaxVertices)) u_lt (
    .clk_i, .we_i(lt_we), .waddr_i(lt_wa), .wdata_i(lt_wd),
    .raddr_i(lt_ra), .rdata_o(lt_rd));
  dcp_ram #(.Width(VIdx), .Depth(MaxVertices)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd));
  dcp_ram #(.Width(VIdx), .Depth(MaxVertices)) u_topo (
    .clk_i, .we_i(to_we), .waddr_i(to_wa), .wdata_i(to_wd),
    .raddr_i(to_ra), .rdata_o(to_rd));
  dcp_ram #(.Width(VcntBits), .Depth(MaxVertices)) u_deg (
    .clk_i, .we_i(dg_we), .waddr_i(dg_wa), .wdata_i(dg_wd),
    .raddr_i(dg_ra), .rdata_o(dg_rd));

  assign r_src = e_rdata[EdgeBits-1 -: VtxBits];
  assign r_dst = e_rdata[WeightBits +: VtxBits];
  assign r_w   = e_rdata[WeightBits-1:0];

  // effective vertex count
  logic [VcntBits-1:0] nv_eff;
  always_comb begin
    nv_eff = vcnt_q;
    if (vcnt_q == '0) nv_eff = VcntBits'(1);
    if (vcnt_q > VcntBits'(MaxVertices)) nv_eff = VcntBits'(MaxVertices);
  end

  assign edge_in.ready = (state_q == SLoad);
  assign crit_out.valid = ov_q;
  assign crit_out.data  = out_q;

  logic [TimeBits-1:0] cand, diff;
  logic [VcntBits-1:0] tdeg;
  logic                out_free;
  assign out_free = !ov_q || crit_out.ready;

  always_comb begin
    state_d = state_q; ecnt_d = ecnt_q; nv_d = nv_q; e_d = e_q; v_d = v_q;
    sp_d = sp_q; done_d = done_q; p_d = p_q; ep_d = ep_q; maxe_d = maxe_q;
    lp_d = lp_q; rv_d = 1'b0; bad_d = bad_q; sub_d = sub_q;
    emitted_d = emitted_q; out_d = out_q; hold_d = hold_q; ov_d = ov_q;
    e_we = 1'b0; e_waddr = ecnt_q[EdgeIdxBits-1:0];
    e_wdata = {edge_in.data.from_vertex, edge_in.data.to_vertex, edge_in.data.weight};
    e_raddr = e_q[EdgeIdxBits-1:0];
    et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = '0;
    lt_we = 1'b0; lt_wa = '0; lt_wd = '0; lt_ra = '0;
    st_we = 1'b0; st_wa = sp_q[VIdx-1:0]; st_wd = '0; st_ra = '0;
    to_we = 1'b0; to_wa = done_q[VIdx-1:0]; to_wd = p_q; to_ra = '0;
    dg_we = 1'b0; dg_wa = '0; dg_wd = '0; dg_ra = '0;
    cand = ep_q + TimeBits'(r_w);
    diff = (lt_rd >= TimeBits'(r_w)) ? lt_rd - TimeBits'(r_w) : '0;
    tdeg = dg_rd - VcntBits'(1);
    if (ov_q && crit_out.ready) ov_d = 1'b0;

    unique case (state_q)
      // load edges one per cycle
      SLoad: begin
        if (edge_in.valid) begin
          if (ecnt_q < CntBits'(MaxEdges)) begin
            e_we = 1'b1;
            ecnt_d = ecnt_q + CntBits'(1);
          end
          if (edge_in.data.last_edge) begin
            state_d = SRange; nv_d = nv_eff; e_d = '0; bad_d = 1'b0;
          end
        end
      end
      // range check scan
      SRange: begin
        if (rv_q && (VcntBits'(r_src) >= nv_q || VcntBits'(r_dst) >= nv_q))
          bad_d = 1'b1;
        if (e_q < ecnt_q) begin
          rv_d = 1'b1; e_d = e_q + CntBits'(1);
        end else if (!rv_q) begin
          if (ecnt_q == '0) begin
            state_d = SLoad;
          end else if (bad_d) begin
            state_d = SErr; out_d = '0; out_d.status = StatusRange;
          end else begin
            state_d = SClr; v_d = '0;
          end
        end
      end
      // clear degrees and earliest times
      SClr: begin
        dg_we = 1'b1; dg_wa = v_q[VIdx-1:0]; dg_wd = '0;
        et_we = 1'b1; et_wa = v_q[VIdx-1:0]; et_wd = '0;
        v_d = v_q + VcntBits'(1);
        if (v_q == VcntBits'(MaxVertices - 1)) begin
          state_d = SDeg; e_d = '0; sub_d = '0;
        end
      end
      // count in-degrees: fetch edge, fetch degree, write back
      SDeg: begin
        unique case (sub_q)
          2'd0: begin
            if (e_q < ecnt_q) begin
              e_d = e_q + CntBits'(1); sub_d = 2'd1;
            end else begin
              state_d = SSeed; v_d = '0; sp_d = '0; done_d = '0;
            end
          end
          2'd1: begin
            dg_ra = r_dst[VIdx-1:0];
            e_raddr = e_q[EdgeIdxBits-1:0] - EdgeIdxBits'(1);
            sub_d = 2'd2;
          end
          default: begin
            dg_we = 1'b1; dg_wa = r_dst[VIdx-1:0]; dg_wd = dg_rd + VcntBits'(1);
            sub_d = 2'd0;
          end
        endcase
      end
      // push zero in-degree vertices in ascending order
      SSeed: begin
        if (sub_q == 2'd0) begin
          dg_ra = v_q[VIdx-1:0]; sub_d = 2'd1;
        end else begin
          if (dg_rd == '0) begin
            st_we = 1'b1; st_wd = v_q[VIdx-1:0]; sp_d = sp_q + VcntBits'(1);
          end
          v_d = v_q + VcntBits'(1);
          sub_d = 2'd0;
          if (v_q == nv_q - VcntBits'(1)) begin
            state_d = SPop;
          end
        end
      end
      // pop a vertex and fetch its earliest time
      SPop: begin
        unique case (sub_q)
          2'd0: begin
            if (done_q < nv_q && sp_q != '0) begin
              st_ra = sp_q[VIdx-1:0] - VIdx'(1);
              sp_d = sp_q - VcntBits'(1);
              sub_d = 2'd1;
            end else if (done_q < nv_q) begin
              state_d = SErr; out_d = '0; out_d.status = StatusCycle;
            end else begin
              state_d = SMax; v_d = '0; maxe_d = '0; sub_d = '0;
            end
          end
          2'd1: begin
            p_d = st_rd; et_ra = st_rd; sub_d = 2'd2;
          end
          default: begin
            ep_d = et_rd;
            to_we = 1'b1;
            done_d = done_q + VcntBits'(1);
            state_d = SFwd; e_d = ecnt_q; sub_d = '0;
          end
        endcase
      end
      // relax out-edges newest first
      SFwd: begin
        unique case (sub_q)
          2'd0: begin
            if (e_q != '0) begin
              e_raddr = EdgeIdxBits'(e_q - CntBits'(1));
              e_d = e_q - CntBits'(1); sub_d = 2'd1;
            end else begin
              state_d = SPop;
            end
          end
          2'd1: begin
            if (r_src == p_q) begin
              et_ra = r_dst[VIdx-1:0]; dg_ra = r_dst[VIdx-1:0];
              e_raddr = e_q[EdgeIdxBits-1:0];
              sub_d = 2'd2;
            end else begin
              sub_d = 2'd0;
            end
          end
          default: begin
            dg_we = 1'b1; dg_wa = r_dst[VIdx-1:0]; dg_wd = tdeg;
            if (cand > et_rd) begin
              et_we = 1'b1; et_wa = r_dst[VIdx-1:0]; et_wd = cand;
            end
            if (tdeg == '0) begin
              st_we = 1'b1; st_wd = r_dst[VIdx-1:0]; sp_d = sp_q + VcntBits'(1);
            end
            sub_d = 2'd0;
          end
        endcase
      end
      // project length, then latest times preset
      SMax: begin
        if (sub_q == 2'd0) begin
          et_ra = v_q[VIdx-1:0]; sub_d = 2'd1;
        end else if (sub_q == 2'd1) begin
          if (et_rd > maxe_q) maxe_d = et_rd;
          v_d = v_q + VcntBits'(1);
          sub_d = 2'd0;
          if (v_q == nv_q - VcntBits'(1)) begin
            sub_d = 2'd2; v_d = '0;
          end
        end else begin
          lt_we = 1'b1; lt_wa = v_q[VIdx-1:0]; lt_wd = maxe_q;
          v_d = v_q + VcntBits'(1);
          if (v_q == nv_q - VcntBits'(1)) begin
            state_d = SBwd; v_d = nv_q; sub_d = 2'd3;
          end
        end
      end
      // backward pass in reverse topological order
      SBwd: begin
        unique case (sub_q)
          2'd3: begin
            if (v_q == '0) begin
              state_d = SEmit; v_d = '0; e_d = ecnt_q; sub_d = '0;
              emitted_d = 1'b0;
            end else begin
              to_ra = v_q[VIdx-1:0] - VIdx'(1);
              v_d = v_q - VcntBits'(1); sub_d = 2'd2;
            end
          end
          2'd2: begin
            p_d = to_rd; lt_ra = to_rd; e_d = '0; sub_d = 2'd1;
          end
          2'd1: begin
            lp_d = lt_rd;
            sub_d = 2'd0;
          end
          default: begin
            if (rv_q) begin
              // target latest is back, edge data still held
              if (diff < lp_q) lp_d = diff;
            end else if (bad_q) begin
              // edge data is back
              bad_d = 1'b0;
              if (r_src == p_q) begin
                lt_ra = r_dst[VIdx-1:0];
                e_raddr = e_q[EdgeIdxBits-1:0] - EdgeIdxBits'(1);
                rv_d = 1'b1;
              end
            end else if (e_q < ecnt_q) begin
              e_d = e_q + CntBits'(1); bad_d = 1'b1;
            end else begin
              lt_we = 1'b1; lt_wa = p_q; lt_wd = lp_q; sub_d = 2'd3;
            end
          end
        endcase
      end
      // emit critical edges per source, newest first
      SEmit: begin
        unique case (sub_q)
          2'd0: begin
            if (e_q != '0) begin
              e_raddr = EdgeIdxBits'(e_q - CntBits'(1));
              e_d = e_q - CntBits'(1); et_ra = v_q[VIdx-1:0]; sub_d = 2'd1;
            end else if (v_q == nv_q - VcntBits'(1)) begin
              if (out_free) begin
                if (emitted_q) begin
                  out_d = hold_q; out_d.last = 1'b1; ov_d = 1'b1;
                end
                state_d = SOut;
              end
            end else begin
              v_d = v_q + VcntBits'(1); e_d = ecnt_q;
            end
          end
          2'd1: begin
            ep_d = et_rd;
            if (r_src == v_q[VtxBits-1:0]) begin
              lt_ra = r_dst[VIdx-1:0]; e_raddr = e_q[EdgeIdxBits-1:0];
              sub_d = 2'd2;
            end else begin
              sub_d = 2'd0;
            end
          end
          default: begin
            if (ep_q + TimeBits'(r_w) == lt_rd) begin
              if (out_free) begin
                // show the previous edge, keep this one until the next
                if (emitted_q) begin
                  out_d = hold_q; ov_d = 1'b1;
                end
                hold_d = '0;
                hold_d.status = StatusOk;
                hold_d.crit_from = r_src; hold_d.crit_to = r_dst;
                hold_d.crit_weight = r_w;
                hold_d.project_length = (maxe_q > TimeBits'({LenBits{1'b1}})) ?
                  {LenBits{1'b1}} : maxe_q[LenBits-1:0];
                emitted_d = 1'b1; sub_d = 2'd0;
              end else begin
                e_raddr = e_q[EdgeIdxBits-1:0]; lt_ra = r_dst[VIdx-1:0];
              end
            end else begin
              sub_d = 2'd0;
            end
          end
        endcase
      end
      // wait until the last item is taken
      SOut: begin
        if (!ov_d) begin
          state_d = SLoad; ecnt_d = '0;
        end
      end
      default: begin
        // error result
        if (out_free) begin
          out_d.last = 1'b1; ov_d = 1'b1; state_d = SOut;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad; ecnt_q <= '0; ov_q <= 1'b0; vcnt_q <= VcntBits'(MaxVertices);
      rv_q <= 1'b0; bad_q <= 1'b0; sub_q <= '0; emitted_q <= 1'b0;
    end else begin
      state_q <= state_d; ecnt_q <= ecnt_d; ov_q <= ov_d; rv_q <= rv_d;
      bad_q <= bad_d; sub_q <= sub_d; emitted_q <= emitted_d;
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    nv_q <= nv_d; e_q <= e_d; v_q <= v_d; sp_q <= sp_d; done_q <= done_d;
    p_q <= p_d; ep_q <= ep_d; maxe_q <= maxe_d; lp_q <= lp_d; out_q <= out_d;
    hold_q <= hold_d;
  end

endmodule

// ===== sv/dcp_ram.sv =====
// ----------------------------------------------------------------------------
// dcp_ram
// Generic single port write, single port read RAM with registered read.
// ----------------------------------------------------------------------------
module dcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/dcp_checker.sv =====
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level checks of the critical path finder.
// ----------------------------------------------------------------------------
module dcp_checker import dcp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input crit_item_t out_data
);

  // no edge item is taken while a result waits
  a_no_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("edge taken during output");

  // error results are single and final
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != StatusOk |-> out_data.last)
    else $error("error item not last");

  // error results carry a zero project length
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != StatusOk |-> out_data.project_length == '0)
    else $error("error item payload");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");

endmodule

bind dag_critical_path dcp_checker u_dcp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(edge_in.ready), .out_valid(crit_out.valid),
  .out_ready(crit_out.ready), .out_data(crit_out.data));

// ===== sim/tb_dag_critical_path.sv =====
// ----------------------------------------------------------------------------
// tb_dag_critical_path
// Self-checking bench: loads random and directed edge graphs, predicts the
// critical edge list of every run and compares it with the block's output
// under several vertex counts and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_dag_critical_path;
  import dcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [VcntBits-1:0] cfg_wdata_i;

  dcp_in_if  edge_in ();
  dcp_out_if crit_out ();

  dag_critical_path u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_in     (edge_in.sink),
    .crit_out    (crit_out.source)
  );

  localparam int unsigned DrainCycles = 15000;

  edge_item_t pend_q[$];
  crit_item_t crit_q[$];
  int         fail_cnt = 0;
  int         snd_idle = 0;
  int         rcv_stall = 0;

  // predictor copy of the edge memory and register
  logic [VtxBits-1:0]    gr_src[MaxEdges];
  logic [VtxBits-1:0]    gr_dst[MaxEdges];
  logic [WeightBits-1:0] gr_w[MaxEdges];
  int                    gr_cnt = 0;
  int                    gr_vcnt = MaxVertices;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run the critical path computation on the stored graph
  task automatic solve_graph();
    int         n;
    int         sp;
    int         done;
    int         k;
    int         indeg[MaxVertices];
    longint     et[MaxVertices];
    longint     lt[MaxVertices];
    int         topo[MaxVertices];
    int         stk[MaxVertices];
    longint     maxe;
    longint     c;
    bit         bad;
    int         p;
    int         t;
    crit_item_t res[MaxEdges];
    crit_item_t r;
    n = gr_vcnt;
    if (n < 1) n = 1;
    if (n > MaxVertices) n = MaxVertices;
    r = '0;
    bad = 1'b0;
    for (int e = 0; e < gr_cnt; e++)
      if (gr_src[e] >= n || gr_dst[e] >= n) bad = 1'b1;
    if (bad) begin
      r.status = StatusRange;
      r.last = 1'b1;
      crit_q.push_back(r);
      return;
    end
    for (int i = 0; i < MaxVertices; i++) begin
      indeg[i] = 0;
      et[i] = 0;
    end
    for (int e = 0; e < gr_cnt; e++) indeg[gr_dst[e]]++;
    sp = 0;
    done = 0;
    for (int i = 0; i < n; i++)
      if (indeg[i] == 0) begin
        stk[sp] = i;
        sp++;
      end
    // lifo topological sort with earliest times
    while (done < n && sp > 0) begin
      sp--;
      p = stk[sp];
      topo[done] = p;
      done++;
      for (int e = gr_cnt - 1; e >= 0; e--) begin
        if (gr_src[e] != p) continue;
        t = gr_dst[e];
        indeg[t]--;
        c = et[p] + gr_w[e];
        if (c > et[t]) et[t] = c;
        if (indeg[t] == 0 && sp < MaxVertices) begin
          stk[sp] = t;
          sp++;
        end
      end
    end
    if (done < n) begin
      r.status = StatusCycle;
      r.last = 1'b1;
      crit_q.push_back(r);
      return;
    end
    // latest times from the project length
    maxe = 0;
    for (int i = 0; i < n; i++) if (et[i] > maxe) maxe = et[i];
    for (int i = 0; i < n; i++) lt[i] = maxe;
    for (int i = n - 1; i >= 0; i--) begin
      p = topo[i];
      for (int e = 0; e < gr_cnt; e++) begin
        if (gr_src[e] != p) continue;
        c = lt[gr_dst[e]] >= gr_w[e] ? lt[gr_dst[e]] - gr_w[e] : 0;
        if (c < lt[p]) lt[p] = c;
      end
    end
    if (maxe > 4194303) maxe = 4194303;
    // zero slack edges, by source, newest first
    k = 0;
    for (int i = 0; i < n; i++)
      for (int e = gr_cnt - 1; e >= 0; e--) begin
        if (gr_src[e] != i) continue;
        if (et[i] + gr_w[e] == lt[gr_dst[e]] && k < MaxEdges) begin
          res[k] = '0;
          res[k].status = StatusOk;
          res[k].crit_from = gr_src[e];
          res[k].crit_to = gr_dst[e];
          res[k].crit_weight = gr_w[e];
          res[k].project_length = maxe[LenBits-1:0];
          k++;
        end
      end
    if (k > 0) res[k-1].last = 1'b1;
    for (int i = 0; i < k; i++) crit_q.push_back(res[i]);
  endtask

  task automatic store_edge(edge_item_t it);
    if (gr_cnt < MaxEdges) begin
      gr_src[gr_cnt] = it.from_vertex;
      gr_dst[gr_cnt] = it.to_vertex;
      gr_w[gr_cnt] = it.weight;
      gr_cnt++;
    end
    if (it.last_edge) begin
      solve_graph();
      gr_cnt = 0;
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // edge item driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_in.valid <= 1'b0;
    end else if (!edge_in.valid || edge_in.ready) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        edge_in.data  <= pend_q.pop_front();
        edge_in.valid <= 1'b1;
      end else begin
        edge_in.valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_out.ready <= 1'b0;
    end else begin
      crit_out.ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // monitor: predict on accepted edges, check accepted results
  always @(posedge clk_i) begin
    crit_item_t want;
    if (rst_ni) begin
      if (edge_in.valid && edge_in.ready) store_edge(edge_in.data);
      if (crit_out.valid && crit_out.ready) begin
        if (crit_q.size() == 0) begin
          $display("%0t unexpected item: expected none actual %h", $time, crit_out.data);
          fail_cnt++;
        end else begin
          want = crit_q.pop_front();
          check_field("status", want.status, crit_out.data.status);
          check_field("crit_from", want.crit_from, crit_out.data.crit_from);
          check_field("crit_to", want.crit_to, crit_out.data.crit_to);
          check_field("crit_weight", want.crit_weight, crit_out.data.crit_weight);
          check_field("project_length", want.project_length,
                      crit_out.data.project_length);
          check_field("last", want.last, crit_out.data.last);
        end
      end
    end
  end

  task automatic add_edge(int f, int t, int w, bit lst);
    edge_item_t it;
    it.from_vertex = VtxBits'(f);
    it.to_vertex = VtxBits'(t);
    it.weight = WeightBits'(w);
    it.last_edge = lst;
    pend_q.push_back(it);
  endtask

  function automatic int pick_weight();
    case ($urandom_range(3))
      0, 1: pick_weight = $urandom_range(3);
      2: pick_weight = $urandom_range(65535);
      default: pick_weight = $urandom_range(1) ? 65535 : 0;
    endcase
  endfunction

  // one graph: 0 dag, 1 dag plus back edge, 2 arbitrary vertices
  task automatic queue_graph(int n, int ne, int kind);
    int perm[MaxVertices];
    int a;
    int b;
    int tmp;
    int back;
    for (int i = 0; i < MaxVertices; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      a = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[a];
      perm[a] = tmp;
    end
    if (n < 2 && kind != 2) kind = 1;
    back = $urandom_range(ne - 1);
    for (int e = 0; e < ne; e++) begin
      if (kind == 2) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
        add_edge(a, b, pick_weight(), e == ne - 1);
      end else if (n < 2) begin
        add_edge(0, 0, pick_weight(), e == ne - 1);
      end else begin
        a = $urandom_range(n - 2);
        b = $urandom_range(n - 1, a + 1);
        if (kind == 1 && e == back) add_edge(perm[b], perm[a], pick_weight(), e == ne - 1);
        else add_edge(perm[a], perm[b], pick_weight(), e == ne - 1);
      end
    end
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || edge_in.valid || crit_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // stimulus and phase control
  initial begin
    int vc_list[8];
    int n;
    int ne;
    int kind;
    int start;
    vc_list = '{64, 8, 1, 0, 127, 2, 16, 40};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 56; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 56; end
        default: begin snd_idle = 30; rcv_stall = 30; end
      endcase
      // vertex count write while idle
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= VcntBits'(vc_list[p]);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      gr_vcnt = vc_list[p];
      n = vc_list[p] < 1 ? 1 : (vc_list[p] > MaxVertices ? MaxVertices : vc_list[p]);
      start = pend_q.size();
      if (p == 0) begin
        // extreme single edges, ties, parallel edges, cycles
        add_edge(0, 63, 65535, 1);
        add_edge(63, 0, 0, 1);
        add_edge(0, 1, 5, 0);
        add_edge(0, 2, 5, 0);
        add_edge(1, 3, 5, 0);
        add_edge(2, 3, 5, 1);
        add_edge(7, 7, 9, 1);
        add_edge(1, 2, 4, 0);
        add_edge(2, 1, 4, 1);
        add_edge(4, 5, 3, 0);
        add_edge(4, 5, 9, 1);
        add_edge(10, 11, 0, 0);
        add_edge(11, 12, 0, 0);
        add_edge(12, 13, 1, 1);
      end
      if (p == 1) begin
        // out of range vertex, also combined with a cycle
        add_edge(8, 0, 1, 0);
        add_edge(0, 63, 2, 1);
        add_edge(3, 3, 1, 0);
        add_edge(9, 1, 1, 1);
      end
      if (p == 4) begin
        // deepest chain, then an overfull edge list
        for (int i = 0; i < 63; i++) add_edge(i, i + 1, 65535, i == 62);
        queue_graph(n, 70, 0);
      end
      while (pend_q.size() - start < 20 + (p == 4 ? 133 : 0)) begin
        kind = $urandom_range(9);
        ne = ($urandom_range(11) == 0) ? $urandom_range(64, 20) : $urandom_range(10, 1);
        queue_graph(n, ne, kind < 7 ? 0 : (kind < 9 ? 1 : 2));
      end
      wait_idle();
    end
    if (fail_cnt == 0) begin
      $display("tb_dag_critical_path passed");
    end else begin
      $display("tb_dag_critical_path failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #100ms;
    $display("tb_dag_critical_path failed");
    $finish;
  end

endmodule
